// ----- src/demand_paged_address_translator_macros.svh -----
// Assertion macros shared by the translator RTL.
`ifndef DEMAND_PAGED_ADDRESS_TRANSLATOR_MACROS_SVH
`define DEMAND_PAGED_ADDRESS_TRANSLATOR_MACROS_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define DPAT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");
// Condition implies a consequence in the same cycle.
`define DPAT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication violated");
// Condition implies a consequence in the next cycle.
`define DPAT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("sequence violated");
`else
`define DPAT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DPAT_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define DPAT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- src/dpat_pkg.sv -----
// Shared payload types and codes for the demand-paged address translator.
package dpat_pkg;

	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 9;

	localparam logic ACT_LOAD      = 1'b0;
	localparam logic ACT_TRANSLATE = 1'b1;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] load_byte;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]        logical_address;
		logic [ADDR_W-1:0]        physical_address;
		logic signed [BYTE_W-1:0] read_value;
		logic                     page_fault;
		logic [CNT_W-1:0]         faults_so_far;
	} rsp_t;

endpackage

// ----- src/dpat_chan_if.sv -----
// Valid/ready channel carrying one payload item per transfer.
interface dpat_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/dpat_page_table.sv -----
// Page table memory (valid bit and frame per page) with a clearing sweep after reset.
module dpat_page_table #(
	parameter int PAGE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [PAGE_BITS-1:0] rd_page,
	input  logic                 wr_en,
	input  logic [PAGE_BITS-1:0] wr_page,
	input  logic [PAGE_BITS-1:0] wr_frame,
	output logic                 rd_valid,
	output logic [PAGE_BITS-1:0] rd_frame,
	output logic                 busy
);
	localparam int NUM_PAGES = 1 << PAGE_BITS;

	logic [PAGE_BITS:0]   table_mem [NUM_PAGES];
	logic [PAGE_BITS:0]   rdata_q;
	logic                 clr_busy_q;
	logic [PAGE_BITS-1:0] clr_idx_q;

	// Sweep every entry once, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			table_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			table_mem[wr_page] <= {1'b1, wr_frame};
		end
		if (rd_en) begin
			rdata_q <= table_mem[rd_page];
		end
	end

	assign rd_valid = rdata_q[PAGE_BITS];
	assign rd_frame = rdata_q[PAGE_BITS-1:0];
	assign busy     = clr_busy_q;
endmodule

// ----- src/demand_paged_address_translator.sv -----
// Page hit: S_LOOKUP reads frame memory off the table data; S_DONE then registers the result.
// Page fault: S_COPY copies the page at one byte per cycle through the single read port of the
// backing memory, then S_DRAIN, S_READ and S_DONE follow. Loads give no result.
// No item is taken until S_IDLE, but a new item is taken while the previous result still waits in the output register.
// Reset: control clears at once; the page table clearing pass then covers all 2**PAGE_BITS entries
// (256 by default), during which no item is accepted.
`include "demand_paged_address_translator_macros.svh"

module demand_paged_address_translator #(
	parameter int OFFSET_BITS = 8,
	parameter int PAGE_BITS   = 8
) (
	input logic        clk,
	input logic        arst_n,
	dpat_chan_if.sink   cmd,
	dpat_chan_if.source rsp
);
	import dpat_pkg::*;

	localparam int MEM_W    = PAGE_BITS + OFFSET_BITS;
	localparam int MEM_SIZE = 1 << MEM_W;
	localparam int EXT_W    = ADDR_W + MEM_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_COPY,
		S_DRAIN,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q;

	// Frame memory holds resident pages, backing memory the whole address space
	logic [BYTE_W-1:0] frame_mem   [MEM_SIZE];
	logic [BYTE_W-1:0] backing_mem [MEM_SIZE];
	logic [BYTE_W-1:0] fmem_rdata_q;
	logic [BYTE_W-1:0] bmem_rdata_q;

	logic [ADDR_W-1:0]      addr_q;
	logic [PAGE_BITS-1:0]   frame_q;
	logic [OFFSET_BITS-1:0] copy_idx_q;
	logic [OFFSET_BITS-1:0] wr_idx_s1;
	logic                   wr_s1;
	logic                   fault_q;
	logic [CNT_W-1:0]       next_free_q;
	logic [CNT_W-1:0]       fault_total_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_data_q;

	logic                   cmd_accept;
	logic                   translate_accept;
	logic                   pt_busy;
	logic                   pt_valid;
	logic [PAGE_BITS-1:0]   pt_frame;
	logic                   pt_wr_en;
	logic [PAGE_BITS-1:0]   new_frame;
	logic [EXT_W-1:0]       cmd_addr_ext;
	logic [EXT_W-1:0]       cur_addr_ext;
	logic [PAGE_BITS-1:0]   cur_page;
	logic [OFFSET_BITS-1:0] cur_offset;
	logic [PAGE_BITS-1:0]   read_frame;
	logic [MEM_W-1:0]       phys_cur;
	logic [EXT_W-1:0]       phys_ext;
	logic                   fmem_re;
	logic                   out_free;

	// Mask addresses to the memory width: zero-extend, then take the low MEM_W bits
	assign cmd_addr_ext = EXT_W'(cmd.data.address);
	assign cur_addr_ext = EXT_W'(addr_q);
	assign cur_page     = cur_addr_ext[MEM_W-1:OFFSET_BITS];
	assign cur_offset   = cur_addr_ext[OFFSET_BITS-1:0];

	assign cmd.ready        = (state_q == S_IDLE);
	assign cmd_accept       = cmd.valid && cmd.ready;
	assign translate_accept = cmd_accept && (cmd.data.action == ACT_TRANSLATE);

	// A fault takes the next free frame, masked to the page width
	assign new_frame = PAGE_BITS'(next_free_q);
	assign pt_wr_en  = (state_q == S_LOOKUP) && !pt_valid;

	dpat_page_table #(
		.PAGE_BITS(PAGE_BITS)
	) u_page_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (translate_accept),
		.rd_page (cmd_addr_ext[MEM_W-1:OFFSET_BITS]),
		.wr_en   (pt_wr_en),
		.wr_page (cur_page),
		.wr_frame(new_frame),
		.rd_valid(pt_valid),
		.rd_frame(pt_frame),
		.busy    (pt_busy)
	);

	// Hit: read frame memory straight off the table data; fault: after the copy drains
	assign fmem_re    = ((state_q == S_LOOKUP) && pt_valid) || (state_q == S_READ);
	assign read_frame = (state_q == S_LOOKUP) ? pt_frame : frame_q;
	assign phys_cur   = {read_frame, cur_offset};
	assign phys_ext   = EXT_W'({frame_q, cur_offset});

	// Backing store: loads write on transfer, the page copy reads one byte a cycle
	always_ff @(posedge clk) begin
		if (cmd_accept && (cmd.data.action == ACT_LOAD)) begin
			backing_mem[cmd_addr_ext[MEM_W-1:0]] <= cmd.data.load_byte;
		end
		if (state_q == S_COPY) begin
			bmem_rdata_q <= backing_mem[{cur_page, copy_idx_q}];
		end
	end

	// Frame memory: copy writes follow the backing reads in the next cycle
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			frame_mem[{frame_q, wr_idx_s1}] <= bmem_rdata_q;
		end
		if (fmem_re) begin
			fmem_rdata_q <= frame_mem[phys_cur];
		end
	end

	// Item payload held for the duration of one translation
	always_ff @(posedge clk) begin
		wr_idx_s1 <= copy_idx_q;
		if (cmd_accept) begin
			addr_q <= cmd.data.address;
		end
		case (state_q)
			S_LOOKUP: begin
				frame_q    <= pt_valid ? pt_frame : new_frame;
				copy_idx_q <= '0;
			end
			S_COPY: begin
				copy_idx_q <= copy_idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	// Sequencer: state, counters and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			wr_s1         <= 1'b0;
			fault_q       <= 1'b0;
			next_free_q   <= '0;
			fault_total_q <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_data_q    <= '0;
		end else begin
			wr_s1 <= (state_q == S_COPY);
			// Drop the result once the sink takes it, unless a new one loads in its place
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (!pt_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_accept && (cmd.data.action == ACT_TRANSLATE)) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (pt_valid) begin
						fault_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						fault_q       <= 1'b1;
						next_free_q   <= next_free_q + 1'b1;
						fault_total_q <= fault_total_q + 1'b1;
						state_q       <= S_COPY;
					end
				end
				S_COPY: begin
					if (copy_idx_q == '1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// Last copy write lands this cycle
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						rsp_valid_q                 <= 1'b1;
						rsp_data_q.logical_address  <= addr_q;
						rsp_data_q.physical_address <= phys_ext[ADDR_W-1:0];
						rsp_data_q.read_value       <= fmem_rdata_q;
						rsp_data_q.page_fault       <= fault_q;
						rsp_data_q.faults_so_far    <= fault_total_q;
						state_q                     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Both counters advance on every fault and nowhere else
	`DPAT_ASSERT_ALWAYS(a_counts_agree, clk, arst_n, fault_total_q == next_free_q)
	// The final copy write is still pending when the copy loop ends
	`DPAT_ASSERT_IMPLY(a_drain_writes, clk, arst_n, state_q == S_DRAIN, wr_s1)
	// Table data is consumed in the cycle after a translate transfer
	`DPAT_ASSERT_NEXT(a_lookup_follows, clk, arst_n, translate_accept, state_q == S_LOOKUP)
endmodule
